### design/max_heap_priority_queue_top_macros.svh
// assertion macros for the max-heap priority queue checker
// used by mhpq_checker.sv; needs clk and arst_n in the including scope
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/mhpq_pkg.sv
// shared types, codes and constants of the max-heap priority queue
// no dependencies; imported by mhpq_dp, mhpq_ctrl, the top level and mhpq_checker
`default_nettype none

package mhpq_pkg;

	localparam int CAPACITY  = 64;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int POS_W     = 6;
	localparam int KEY_W     = 32;
	localparam int PAY_W     = 8;
	localparam int POS_CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic signed [KEY_W-1:0] KEY_SENTINEL  = 32'sh8000_0001;
	localparam logic signed [KEY_W-1:0] KEY_MIN       = 32'sh8000_0000;
	localparam logic [PAY_W-1:0]        EMPTY_PAYLOAD = 8'd79;

	typedef enum logic [1:0] {
		OP_PEEK     = 2'd0,
		OP_EXTRACT  = 2'd1,
		OP_INCREASE = 2'd2,
		OP_INSERT   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_REJECT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		op_t                     operation;
		logic [POS_W-1:0]        position;
		logic signed [KEY_W-1:0] new_key;
		logic [PAY_W-1:0]        payload;
	} req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] top_key;
		logic [PAY_W-1:0]        top_payload;
		status_t                 status;
	} rsp_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        pay;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// read port selection
	typedef enum logic [1:0] {
		RD_ROOT   = 2'd0,
		RD_POS    = 2'd1,
		RD_PARENT = 2'd2,
		RD_CHILD  = 2'd3
	} rd_sel_t;

	// write source selection
	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_UP   = 2'd1,
		WR_DOWN = 2'd2,
		WR_CUR  = 2'd3
	} wr_sel_t;

	// update of position, moving entry and count
	typedef enum logic [2:0] {
		LD_NONE     = 3'd0,
		LD_EXTRACT  = 3'd1,
		LD_INCREASE = 3'd2,
		LD_INSERT   = 3'd3,
		LD_UP       = 3'd4,
		LD_DOWN     = 3'd5
	} ld_sel_t;

	typedef enum logic [1:0] {
		RES_HOLD = 2'd0,
		RES_SET  = 2'd1,
		RES_TOP  = 2'd2
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		rd_sel_t  rd_sel;
		wr_sel_t  wr_sel;
		ld_sel_t  ld_sel;
		res_sel_t res_sel;
		status_t  res_status;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic pos_bad;
		logic key_is_min;
		logic inc_low;
		logic at_root;
		logic up_swap;
		logic dn_leaf;
		logic dn_swap;
	} flags_t;

endpackage

`default_nettype wire

### design/mhpq_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
`default_nettype none

module mhpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

### design/mhpq_dp.sv
// heap datapath: request and result registers, heap memory, sift compares
// depends on mhpq_pkg and mhpq_ram
`default_nettype none

module mhpq_dp
	import mhpq_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire req_t   req,
	input  wire cmd_t   cmd,
	output flags_t      flags,
	output rsp_t        rsp
);

	req_t               req_q;
	logic [CNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]  at_q;
	entry_t             cur_q;
	entry_t             res_q;
	status_t            res_status_q;
	rsp_t               rsp_q;

	entry_t             rd_a;
	entry_t             rd_b;
	logic               we;
	logic [ADDR_W-1:0]  raddr_a;
	logic [ADDR_W-1:0]  raddr_b;
	entry_t             wdata;

	logic [ADDR_W-1:0]  last_addr;
	logic [ADDR_W-1:0]  parent;
	logic [ADDR_W:0]    left;
	logic [ADDR_W+1:0]  right;
	logic               right_in;
	logic               l_gt;
	logic signed [KEY_W-1:0] best_key;
	logic               pick_b;
	logic [ADDR_W-1:0]  big_addr;

	mhpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_heap_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (at_q),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// tree navigation
	assign last_addr = ADDR_W'(count_q - CNT_W'(1));
	assign parent    = ADDR_W'((at_q - ADDR_W'(1)) >> 1);
	assign left      = {at_q, 1'b1};
	assign right     = {1'b0, at_q, 1'b1} + (ADDR_W+2)'(1);
	assign right_in  = right < {1'b0, count_q};

	// pick the larger child, left wins ties
	assign l_gt     = $signed(rd_a.key) > $signed(cur_q.key);
	assign best_key = l_gt ? rd_a.key : cur_q.key;
	assign pick_b   = right_in && ($signed(rd_b.key) > $signed(best_key));
	assign big_addr = pick_b ? ADDR_W'(right) : ADDR_W'(left);

	always_comb begin
		flags.op         = req_q.operation;
		flags.empty      = count_q == '0;
		flags.full       = count_q == CNT_W'(CAPACITY);
		flags.pos_bad    = POS_CMP_W'(req_q.position) >= POS_CMP_W'(count_q);
		flags.key_is_min = req_q.new_key == KEY_MIN;
		flags.inc_low    = $signed(req_q.new_key) < $signed(rd_a.key);
		flags.at_root    = at_q == '0;
		flags.up_swap    = $signed(rd_a.key) < $signed(cur_q.key);
		flags.dn_leaf    = left >= count_q;
		flags.dn_swap    = l_gt || pick_b;
	end

	always_comb begin
		raddr_b = last_addr;
		unique case (cmd.rd_sel)
			RD_ROOT:   raddr_a = '0;
			RD_POS:    raddr_a = ADDR_W'(req_q.position);
			RD_PARENT: raddr_a = parent;
			RD_CHILD: begin
				raddr_a = ADDR_W'(left);
				raddr_b = ADDR_W'(right);
			end
			default:   raddr_a = '0;
		endcase
	end

	always_comb begin
		we = cmd.wr_sel != WR_NONE;
		unique case (cmd.wr_sel)
			WR_UP:   wdata = rd_a;
			WR_DOWN: wdata = pick_b ? rd_b : rd_a;
			WR_CUR:  wdata = cur_q;
			default: wdata = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (cmd.ld_sel == LD_EXTRACT) begin
				count_q <= count_q - CNT_W'(1);
			end else if (cmd.ld_sel == LD_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end

		unique case (cmd.ld_sel)
			LD_EXTRACT: begin
				at_q  <= '0;
				cur_q <= rd_b;
			end
			LD_INCREASE: begin
				at_q      <= ADDR_W'(req_q.position);
				cur_q.key <= req_q.new_key;
				cur_q.pay <= rd_a.pay;
			end
			LD_INSERT: begin
				at_q      <= ADDR_W'(count_q);
				cur_q.key <= flags.key_is_min ? KEY_SENTINEL : req_q.new_key;
				cur_q.pay <= req_q.payload;
			end
			LD_UP:   at_q <= parent;
			LD_DOWN: at_q <= big_addr;
			default: ;
		endcase

		unique case (cmd.res_sel)
			RES_SET: begin
				res_q.key    <= '0;
				res_q.pay    <= (cmd.res_status == ST_EMPTY) ? EMPTY_PAYLOAD : '0;
				res_status_q <= cmd.res_status;
			end
			RES_TOP: begin
				res_q        <= rd_a;
				res_status_q <= ST_OK;
			end
			default: ;
		endcase

		if (cmd.out_load) begin
			rsp_q.top_key     <= res_q.key;
			rsp_q.top_payload <= res_q.pay;
			rsp_q.status      <= res_status_q;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

### design/mhpq_ctrl.sv
// heap controller: one-hot sequencer and output valid register
// depends on mhpq_pkg
`default_nettype none

module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   req_valid,
	output logic        req_stall,
	output logic        rsp_valid,
	input  wire logic   rsp_stall,
	input  wire flags_t flags,
	output cmd_t        cmd
);

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_DECODE  = 10'b00_0000_0010,
		S_TOP     = 10'b00_0000_0100,
		S_INC_CHK = 10'b00_0000_1000,
		S_UP_RD   = 10'b00_0001_0000,
		S_UP_CMP  = 10'b00_0010_0000,
		S_DN_RD   = 10'b00_0100_0000,
		S_DN_CMP  = 10'b00_1000_0000,
		S_WRITE   = 10'b01_0000_0000,
		S_FINISH  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d        = state_q;
		cmd.capture    = 1'b0;
		cmd.rd_sel     = RD_ROOT;
		cmd.wr_sel     = WR_NONE;
		cmd.ld_sel     = LD_NONE;
		cmd.res_sel    = RES_HOLD;
		cmd.res_status = ST_OK;
		cmd.out_load   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (flags.op)
					OP_PEEK, OP_EXTRACT: begin
						if (flags.empty) begin
							cmd.res_sel    = RES_SET;
							cmd.res_status = ST_EMPTY;
							state_d        = S_FINISH;
						end else begin
							cmd.rd_sel = RD_ROOT;
							state_d    = S_TOP;
						end
					end
					OP_INCREASE: begin
						cmd.res_sel = RES_SET;
						if (flags.pos_bad) begin
							cmd.res_status = ST_REJECT;
							state_d        = S_FINISH;
						end else begin
							cmd.rd_sel = RD_POS;
							state_d    = S_INC_CHK;
						end
					end
					OP_INSERT: begin
						cmd.res_sel = RES_SET;
						if (flags.full) begin
							cmd.res_status = ST_FULL;
							state_d        = S_FINISH;
						end else begin
							cmd.ld_sel     = LD_INSERT;
							cmd.res_status = flags.key_is_min ? ST_REJECT : ST_OK;
							state_d        = S_UP_RD;
						end
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_TOP: begin
				cmd.res_sel = RES_TOP;
				if (flags.op == OP_EXTRACT) begin
					cmd.ld_sel = LD_EXTRACT;
					state_d    = S_DN_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_INC_CHK: begin
				if (flags.inc_low) begin
					cmd.res_sel    = RES_SET;
					cmd.res_status = ST_REJECT;
					state_d        = S_FINISH;
				end else begin
					cmd.ld_sel = LD_INCREASE;
					state_d    = S_UP_RD;
				end
			end
			S_UP_RD: begin
				if (flags.at_root) begin
					state_d = S_WRITE;
				end else begin
					cmd.rd_sel = RD_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (flags.up_swap) begin
					cmd.wr_sel = WR_UP;
					cmd.ld_sel = LD_UP;
					state_d    = S_UP_RD;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_DN_RD: begin
				if (flags.dn_leaf) begin
					state_d = S_WRITE;
				end else begin
					cmd.rd_sel = RD_CHILD;
					state_d    = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (flags.dn_swap) begin
					cmd.wr_sel = WR_DOWN;
					cmd.ld_sel = LD_DOWN;
					state_d    = S_DN_RD;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.wr_sel = WR_CUR;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### design/max_heap_priority_queue_top.sv
// top level of the max-heap priority queue: controller plus datapath
// depends on mhpq_pkg, mhpq_ctrl, mhpq_dp (and mhpq_ram below it)
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  operation, position, new_key, payload
//   rsp      out  rsp_valid / rsp_stall  top_key, top_payload, status
//
// one transaction in at a time; the next is taken the cycle after the response loads
// after the accept the request is decoded; empty, full and out-of-range cases go
// straight to finish, peek reads the root, a lower increase key is rejected after a
// read; insert and increase sift up, extract sifts down, then the entry is written
// reset clears the entry count and the handshake state; the ram is not cleared
// a finished response waits in the output register while rsp_stall is high
`default_nettype none

module max_heap_priority_queue_top
	import mhpq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// command and status between sequencer and datapath
	cmd_t   cmd;
	flags_t flags;

	// sequencer: decode, sift loops, output handshake
	mhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.flags    (flags),
		.cmd      (cmd)
	);

	// datapath: heap ram, entry count, moving entry, result registers
	mhpq_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.flags (flags),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

### design/mhpq_checker.sv
// port-level checks of the max-heap priority queue, bound to the top level
// depends on mhpq_pkg and max_heap_priority_queue_top_macros.svh
`default_nettype none

`include "max_heap_priority_queue_top_macros.svh"

module mhpq_checker
	import mhpq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// stalled response holds
	`MHPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")

	// empty heap returns key 0 and the empty marker
	`MHPQ_ASSERT_NOW(a_empty_rsp, rsp_valid && rsp.status == ST_EMPTY, rsp.top_key == '0 && rsp.top_payload == EMPTY_PAYLOAD, "bad empty response")

	// rejected or full requests return zeros
	`MHPQ_ASSERT_NOW(a_err_rsp, rsp_valid && (rsp.status == ST_REJECT || rsp.status == ST_FULL), rsp.top_key == '0 && rsp.top_payload == '0, "bad error response")

	// one request in flight: busy right after an accept
	`MHPQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted back to back")

	// a response only appears after the block was busy
	`MHPQ_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(req_stall), "response without work")

endmodule

bind max_heap_priority_queue_top mhpq_checker u_checker (.*);

`default_nettype wire
